/* design/egsa_pkg.sv */
package egsa_pkg;

  // Request codes on req_type.
  localparam logic [1:0] REQ_CLEAR = 2'd0;
  localparam logic [1:0] REQ_ACCUM = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  // Result status codes.
  localparam logic [1:0] STS_DONE  = 2'd0;
  localparam logic [1:0] STS_PAD   = 2'd1;
  localparam logic [1:0] STS_RANGE = 2'd2;
  localparam logic [1:0] STS_SAT   = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] REG_PADDING_ENABLE = 2'd0;
  localparam logic [1:0] REG_PADDING_ROW    = 2'd1;
  localparam logic [1:0] REG_NUM_ROWS       = 2'd2;
  localparam logic [1:0] REG_ROW_WIDTH      = 2'd3;

  // Field and storage widths.
  localparam int ROW_ID_W = 16;
  localparam int COL_W    = 6;
  localparam int DATA_W   = 32;
  localparam int CFG_W    = 9;
  localparam int EPOCH_W  = 8;
  localparam int ENTRY_W  = DATA_W + EPOCH_W;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_CALC,
    ST_CLEAR
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic mem_read;
    logic commit;
    logic sweep_step;
    logic epoch_next;
    logic epoch_restart;
    logic emit_plain;
  } egsa_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic req_clear;
    logic lookup;
    logic epoch_last;
    logic sweep_last;
  } egsa_stat_t;

endpackage

/* design/embedding_grad_scatter_add.sv */
// Embedding-gradient scatter-add table of MAX_ROWS x MAX_WIDTH signed Q16.16
// accumulators.
// Requests: drive req_type, row_id, col and grad_value with start high; the
// transfer happens at a clock edge where start is high and busy is low.
// Each request gives one result on status and value, marked by done for one
// cycle; the receiver cannot stall, so it must take the result then.
// Configuration: cfg_write with cfg_index and cfg_data writes one register
// (0 padding_enable, 1 padding_row, 2 num_rows, 3 row_width) at that edge.
// Clears that do not sweep, padding and range errors register their result
// from the execute state; read and accumulate go through the registered read
// of the table RAM followed by the add and write-back. Busy stays high until
// the result is registered, so a new request can follow in the cycle done
// is shown.
// Clears bump a tag kept with every entry; every 255th clear instead sweeps
// the whole table, all MAX_ROWS*MAX_WIDTH entries, before its result.
// After reset the same sweep runs over the whole table with busy high and no
// result; registers return to their reset values at once.
module embedding_grad_scatter_add #(
  parameter int MAX_ROWS  = 256,
  parameter int MAX_WIDTH = 64
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  input  logic [1:0]                            req_type,
  input  logic signed [egsa_pkg::ROW_ID_W-1:0]  row_id,
  input  logic [egsa_pkg::COL_W-1:0]            col,
  input  logic signed [egsa_pkg::DATA_W-1:0]    grad_value,
  output logic                                  done,
  output logic [1:0]                            status,
  output logic signed [egsa_pkg::DATA_W-1:0]    value,
  input  logic                                  cfg_write,
  input  logic [1:0]                            cfg_index,
  input  logic [egsa_pkg::CFG_W-1:0]            cfg_data
);

  egsa_pkg::egsa_cmd_t  cmd;
  egsa_pkg::egsa_stat_t stat;

  egsa_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .stat (stat),
    .busy (busy),
    .cmd  (cmd)
  );

  egsa_datapath #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_WIDTH(MAX_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req_type  (req_type),
    .row_id    (row_id),
    .col       (col),
    .grad_value(grad_value),
    .done      (done),
    .status    (status),
    .value     (value)
  );

endmodule

/* design/egsa_ram.sv */
module egsa_ram #(
  parameter int WIDTH  = 40,
  parameter int DEPTH  = 16384,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* design/egsa_ctrl.sv */
module egsa_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  egsa_pkg::egsa_stat_t  stat,
  output logic                  busy,
  output egsa_pkg::egsa_cmd_t   cmd
);

  egsa_pkg::state_t state;
  egsa_pkg::state_t state_next;

  // State register; reset starts the sweep that zeroes the table.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= egsa_pkg::ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b1;
    unique case (state)
      egsa_pkg::ST_INIT: begin
        cmd.sweep_step = 1'b1;
        if (stat.sweep_last) begin
          state_next = egsa_pkg::ST_IDLE;
        end
      end
      egsa_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.capture = 1'b1;
          state_next  = egsa_pkg::ST_EXEC;
        end
      end
      egsa_pkg::ST_EXEC: begin
        priority if (stat.req_clear && stat.epoch_last) begin
          // Tags are about to wrap, so the table is swept for real.
          cmd.epoch_restart = 1'b1;
          state_next        = egsa_pkg::ST_CLEAR;
        end else if (stat.req_clear) begin
          cmd.epoch_next = 1'b1;
          cmd.emit_plain = 1'b1;
          state_next     = egsa_pkg::ST_IDLE;
        end else if (stat.lookup) begin
          cmd.mem_read = 1'b1;
          state_next   = egsa_pkg::ST_CALC;
        end else begin
          cmd.emit_plain = 1'b1;
          state_next     = egsa_pkg::ST_IDLE;
        end
      end
      egsa_pkg::ST_CALC: begin
        cmd.commit = 1'b1;
        state_next = egsa_pkg::ST_IDLE;
      end
      egsa_pkg::ST_CLEAR: begin
        cmd.sweep_step = 1'b1;
        if (stat.sweep_last) begin
          cmd.emit_plain = 1'b1;
          state_next     = egsa_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = egsa_pkg::ST_INIT;
      end
    endcase
  end

endmodule

/* design/egsa_datapath.sv */
module egsa_datapath #(
  parameter int MAX_ROWS  = 256,
  parameter int MAX_WIDTH = 64
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  egsa_pkg::egsa_cmd_t                   cmd,
  output egsa_pkg::egsa_stat_t                  stat,
  input  logic                                  cfg_write,
  input  logic [1:0]                            cfg_index,
  input  logic [egsa_pkg::CFG_W-1:0]            cfg_data,
  input  logic [1:0]                            req_type,
  input  logic signed [egsa_pkg::ROW_ID_W-1:0]  row_id,
  input  logic [egsa_pkg::COL_W-1:0]            col,
  input  logic signed [egsa_pkg::DATA_W-1:0]    grad_value,
  output logic                                  done,
  output logic [1:0]                            status,
  output logic signed [egsa_pkg::DATA_W-1:0]    value
);

  localparam int DEPTH  = MAX_ROWS * MAX_WIDTH;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // Configuration registers.
  logic       padding_enable;
  logic [7:0] padding_row;
  logic [8:0] num_rows;
  logic [6:0] row_width;

  // Captured request.
  logic [1:0]                           req_q;
  logic [egsa_pkg::ROW_ID_W-1:0]        row_q;
  logic [egsa_pkg::COL_W-1:0]           col_q;
  logic [egsa_pkg::DATA_W-1:0]          grad_q;

  logic [egsa_pkg::EPOCH_W-1:0]         epoch;
  logic [ADDR_W-1:0]                    sweep_addr;

  logic                                 row_neg;
  logic                                 row_ok;
  logic                                 col_ok;
  logic                                 pad_hit;
  logic [1:0]                           early_status;
  logic [31:0]                          addr_full;
  logic [ADDR_W-1:0]                    addr;

  logic                                 ram_we;
  logic [ADDR_W-1:0]                    ram_waddr;
  logic [egsa_pkg::ENTRY_W-1:0]         ram_wdata;
  logic [egsa_pkg::ENTRY_W-1:0]         ram_rdata;

  logic [egsa_pkg::DATA_W-1:0]          old_val;
  logic [egsa_pkg::DATA_W:0]            sum;
  logic                                 ovf;
  logic [egsa_pkg::DATA_W-1:0]          acc_val;

  // Configuration writes are taken at any time.
  always_ff @(posedge clk) begin
    if (rst) begin
      padding_enable <= 1'b0;
      padding_row    <= 8'd0;
      num_rows       <= 9'd256;
      row_width      <= 7'd64;
    end else if (cfg_write) begin
      unique case (cfg_index)
        egsa_pkg::REG_PADDING_ENABLE: padding_enable <= cfg_data[0];
        egsa_pkg::REG_PADDING_ROW:    padding_row    <= cfg_data[7:0];
        egsa_pkg::REG_NUM_ROWS:       num_rows       <= cfg_data;
        egsa_pkg::REG_ROW_WIDTH:      row_width      <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // Request capture on an accepted transfer.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_q  <= req_type;
      row_q  <= row_id;
      col_q  <= col;
      grad_q <= grad_value;
    end
  end

  // Request classification: padding first, then range.
  always_comb begin
    row_neg = row_q[egsa_pkg::ROW_ID_W-1];
    row_ok  = !row_neg && ({1'b0, row_q} < {8'd0, num_rows})
              && ({1'b0, row_q} < 17'(MAX_ROWS));
    col_ok  = ({1'b0, col_q} < row_width) && (32'(col_q) < 32'(MAX_WIDTH));
    pad_hit = (req_q == egsa_pkg::REQ_ACCUM) && padding_enable && !row_neg
              && (row_q == {8'd0, padding_row});
    priority if (req_q == egsa_pkg::REQ_CLEAR) begin
      early_status = egsa_pkg::STS_DONE;
    end else if (req_q != egsa_pkg::REQ_ACCUM && req_q != egsa_pkg::REQ_READ) begin
      early_status = egsa_pkg::STS_RANGE;
    end else if (pad_hit) begin
      early_status = egsa_pkg::STS_PAD;
    end else begin
      early_status = egsa_pkg::STS_RANGE;
    end
    stat.req_clear  = (req_q == egsa_pkg::REQ_CLEAR);
    stat.lookup     = (req_q == egsa_pkg::REQ_ACCUM || req_q == egsa_pkg::REQ_READ)
                      && !pad_hit && row_ok && col_ok;
    stat.epoch_last = (epoch == '1);
    stat.sweep_last = (sweep_addr == ADDR_W'(DEPTH - 1));
    addr_full = 32'(row_q[egsa_pkg::ROW_ID_W-2:0]) * 32'(MAX_WIDTH) + 32'(col_q);
    addr      = addr_full[ADDR_W-1:0];
  end

  // Clear epoch; entries tagged with another epoch read as zero.
  always_ff @(posedge clk) begin
    if (rst || cmd.epoch_restart) begin
      epoch <= egsa_pkg::EPOCH_W'(1);
    end else if (cmd.epoch_next) begin
      epoch <= epoch + egsa_pkg::EPOCH_W'(1);
    end
  end

  // Sweep address runs over the whole table, then returns to zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_addr <= '0;
    end else if (cmd.sweep_step) begin
      sweep_addr <= stat.sweep_last ? '0 : sweep_addr + ADDR_W'(1);
    end
  end

  // Saturating accumulate on the looked-up entry.
  always_comb begin
    old_val = (ram_rdata[egsa_pkg::ENTRY_W-1:egsa_pkg::DATA_W] == epoch)
              ? ram_rdata[egsa_pkg::DATA_W-1:0] : '0;
    sum     = {old_val[egsa_pkg::DATA_W-1], old_val}
              + {grad_q[egsa_pkg::DATA_W-1], grad_q};
    ovf     = sum[egsa_pkg::DATA_W] != sum[egsa_pkg::DATA_W-1];
    acc_val = ovf ? {sum[egsa_pkg::DATA_W], {(egsa_pkg::DATA_W-1){!sum[egsa_pkg::DATA_W]}}}
                  : sum[egsa_pkg::DATA_W-1:0];
  end

  // Table write port: sweep zeroes tags, an accumulate's commit stores the new sum.
  always_comb begin
    ram_we    = cmd.sweep_step || (cmd.commit && req_q == egsa_pkg::REQ_ACCUM);
    ram_waddr = cmd.sweep_step ? sweep_addr : addr;
    ram_wdata = cmd.sweep_step ? '0 : {epoch, acc_val};
  end

  egsa_ram #(
    .WIDTH (egsa_pkg::ENTRY_W),
    .DEPTH (DEPTH),
    .ADDR_W(ADDR_W)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (cmd.mem_read),
    .raddr(addr),
    .rdata(ram_rdata)
  );

  // Result registers and strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.emit_plain || cmd.commit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_plain) begin
      status <= early_status;
      value  <= '0;
    end else if (cmd.commit) begin
      if (req_q == egsa_pkg::REQ_ACCUM) begin
        status <= ovf ? egsa_pkg::STS_SAT : egsa_pkg::STS_DONE;
        value  <= acc_val;
      end else begin
        status <= egsa_pkg::STS_DONE;
        value  <= old_val;
      end
    end
  end

endmodule

/* dv/tb_embedding_grad_scatter_add.sv */
module tb_embedding_grad_scatter_add;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_ROWS    = 256;
  localparam int MAX_WIDTH   = 64;
  localparam int IDLE_PCT    = 36;
  localparam int CYCLE_LIMIT = 300_000;

  // One request as driven on the request ports.
  typedef struct {
    logic [1:0]  kind;
    logic [15:0] row;
    logic [5:0]  col;
    logic [31:0] grad;
  } grad_req_t;

  // One result as seen on the result ports.
  typedef struct {
    logic [1:0]         status;
    logic signed [31:0] value;
  } grad_rsp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [1:0] req_type = egsa_pkg::REQ_CLEAR;
  logic signed [egsa_pkg::ROW_ID_W-1:0] row_id = '0;
  logic [egsa_pkg::COL_W-1:0] col = '0;
  logic signed [egsa_pkg::DATA_W-1:0] grad_value = '0;
  logic cfg_write = 1'b0;
  logic [1:0] cfg_index = egsa_pkg::REG_PADDING_ENABLE;
  logic [egsa_pkg::CFG_W-1:0] cfg_data = '0;
  logic busy;
  logic done;
  logic [1:0] status;
  logic signed [egsa_pkg::DATA_W-1:0] value;

  // Mirror of the configuration registers, at their reset values.
  logic       pad_enable_reg  = 1'b0;
  logic [7:0] padding_row_reg = 8'd0;
  logic [8:0] num_rows_reg    = 9'd256;
  logic [6:0] row_width_reg   = 7'd64;

  // Shadow copy of the gradient table; a missing key reads as zero.
  logic signed [31:0] shadow_table [int unsigned];

  grad_req_t pending_requests[$];
  grad_rsp_t predicted_entries[$];
  bit        hold_no_idle = 1'b0;
  int        fail_count = 0;
  int        cycle_count = 0;

  embedding_grad_scatter_add #(
    .MAX_ROWS  (MAX_ROWS),
    .MAX_WIDTH (MAX_WIDTH)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .req_type   (req_type),
    .row_id     (row_id),
    .col        (col),
    .grad_value (grad_value),
    .done       (done),
    .status     (status),
    .value      (value),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Update the shadow table for one request and return the result it gives.
  function automatic grad_rsp_t apply_request(grad_req_t rq);
    grad_rsp_t          rsp;
    int unsigned        rows_used;
    int unsigned        cols_used;
    int unsigned        key;
    logic signed [31:0] old;
    logic signed [32:0] sum;
    bit                 in_range;
    rows_used = (num_rows_reg > MAX_ROWS) ? MAX_ROWS : num_rows_reg;
    cols_used = (row_width_reg > MAX_WIDTH) ? MAX_WIDTH : row_width_reg;
    in_range = !rq.row[15] && rq.row < rows_used && rq.col < cols_used;
    key = rq.row * MAX_WIDTH + rq.col;
    rsp.status = egsa_pkg::STS_DONE;
    rsp.value = '0;
    if (rq.kind == egsa_pkg::REQ_CLEAR) begin
      shadow_table.delete();
    end else if (rq.kind == egsa_pkg::REQ_ACCUM && pad_enable_reg && !rq.row[15] &&
                 rq.row == {8'd0, padding_row_reg}) begin
      rsp.status = egsa_pkg::STS_PAD;
    end else if (!in_range ||
                 (rq.kind != egsa_pkg::REQ_ACCUM && rq.kind != egsa_pkg::REQ_READ)) begin
      rsp.status = egsa_pkg::STS_RANGE;
    end else begin
      old = shadow_table.exists(key) ? shadow_table[key] : '0;
      if (rq.kind == egsa_pkg::REQ_READ) begin
        rsp.value = old;
      end else begin
        // A carry out that disagrees with the sign bit means the sum left 32 bits.
        sum = {old[31], old} + {rq.grad[31], rq.grad};
        if (sum[32] != sum[31]) begin
          rsp.status = egsa_pkg::STS_SAT;
          rsp.value = sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else begin
          rsp.value = sum[31:0];
        end
        shadow_table[key] = rsp.value;
      end
    end
    return rsp;
  endfunction

  // Request driver: predicts each transfer and presents the next queued request.
  always @(posedge clk) begin : drive_requests
    grad_req_t head;
    if (rst) begin
      start <= 1'b0;
    end else if (!start || !busy) begin
      if (start) begin
        predicted_entries.push_back(apply_request(pending_requests.pop_front()));
      end
      if (pending_requests.size() != 0 &&
          (hold_no_idle || $urandom_range(99) >= IDLE_PCT)) begin
        head = pending_requests[0];
        start <= 1'b1;
        req_type <= head.kind;
        row_id <= head.row;
        col <= head.col;
        grad_value <= head.grad;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Result monitor: each strobed result must match the oldest prediction.
  always @(posedge clk) begin : check_results
    grad_rsp_t want;
    if (!rst && done) begin
      if (predicted_entries.size() == 0) begin
        $error("result with no request outstanding: status %0d value %0d", status, value);
        fail_count++;
      end else begin
        want = predicted_entries.pop_front();
        if (status !== want.status) begin
          $error("status mismatch: expected %0d, actual %0d", want.status, status);
          fail_count++;
        end
        if (value !== want.value) begin
          $error("value mismatch: expected %0d, actual %0d", want.value, value);
          fail_count++;
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic queue_request(logic [1:0] kind, logic [15:0] row, logic [5:0] column,
                               logic [31:0] grad);
    grad_req_t rq;
    rq.kind = kind;
    rq.row = row;
    rq.col = column;
    rq.grad = grad;
    pending_requests.push_back(rq);
  endtask

  // Random requests, mostly aimed at a small corner of the table so that sums
  // build up and saturate, with some ids and columns drawn over their whole range.
  task automatic queue_random(int count, int clear_pct, int row_span, int col_span);
    logic [1:0]  kind;
    logic [15:0] row;
    logic [5:0]  column;
    logic [31:0] grad;
    int          pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < clear_pct) begin
        kind = egsa_pkg::REQ_CLEAR;
      end else if ($urandom_range(99) < 60) begin
        kind = egsa_pkg::REQ_ACCUM;
      end else begin
        kind = egsa_pkg::REQ_READ;
      end
      case ($urandom_range(15))
        0: row = 16'($urandom);
        1: row = {8'd0, padding_row_reg};
        2: row = 16'($urandom_range(0, MAX_ROWS + 1));
        default: row = 16'($urandom_range(0, row_span - 1));
      endcase
      if ($urandom_range(7) == 0) begin
        column = 6'($urandom_range(0, 63));
      end else begin
        column = 6'($urandom_range(0, col_span - 1));
      end
      case ($urandom_range(7))
        0, 1: grad = $urandom;
        2: grad = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
        3: grad = $urandom_range(1) ? 32'h4000_0000 + $urandom_range(0, 2 ** 24)
                                    : 32'hC000_0000 - $urandom_range(0, 2 ** 24);
        default: grad = int'($urandom_range(0, 2097152)) - 1048576;
      endcase
      queue_request(kind, row, column, grad);
    end
  endtask

  task automatic write_reg(logic [1:0] index, logic [egsa_pkg::CFG_W-1:0] data);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= index;
    cfg_data <= data;
    case (index)
      egsa_pkg::REG_PADDING_ENABLE: pad_enable_reg = data[0];
      egsa_pkg::REG_PADDING_ROW:    padding_row_reg = data[7:0];
      egsa_pkg::REG_NUM_ROWS:       num_rows_reg = data[8:0];
      egsa_pkg::REG_ROW_WIDTH:      row_width_reg = data[6:0];
      default: ;
    endcase
  endtask

  // Writes all four registers, then drops cfg_write before new requests.
  task automatic set_config(logic enable, logic [7:0] pad_row, logic [8:0] rows,
                            logic [6:0] width);
    write_reg(egsa_pkg::REG_PADDING_ENABLE, egsa_pkg::CFG_W'(enable));
    write_reg(egsa_pkg::REG_PADDING_ROW, egsa_pkg::CFG_W'(pad_row));
    write_reg(egsa_pkg::REG_NUM_ROWS, egsa_pkg::CFG_W'(rows));
    write_reg(egsa_pkg::REG_ROW_WIDTH, egsa_pkg::CFG_W'(width));
    @(posedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
  endtask

  // Waits until every queued request has been transferred and answered.
  task automatic drain;
    @(negedge clk);
    while (pending_requests.size() != 0 || predicted_entries.size() != 0 || start) begin
      @(negedge clk);
    end
    repeat (4) @(negedge clk);
  endtask

  initial begin : run_test
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset values: saturation both ways, table corners and ids out of range.
    queue_request(egsa_pkg::REQ_READ, 16'd0, 6'd0, 32'h0);
    queue_request(egsa_pkg::REQ_ACCUM, 16'd0, 6'd0, 32'h7FFF_FFFF);
    queue_request(egsa_pkg::REQ_ACCUM, 16'd0, 6'd0, 32'h0000_0001);
    queue_request(egsa_pkg::REQ_ACCUM, 16'd0, 6'd0, 32'h8000_0000);
    queue_request(egsa_pkg::REQ_ACCUM, 16'd255, 6'd63, 32'h8000_0000);
    queue_request(egsa_pkg::REQ_ACCUM, 16'd255, 6'd63, 32'hFFFF_FFFF);
    queue_request(egsa_pkg::REQ_READ, 16'd255, 6'd63, 32'hFFFF_FFFF);
    queue_request(egsa_pkg::REQ_READ, 16'hFFFF, 6'd0, 32'h0);
    queue_request(egsa_pkg::REQ_ACCUM, 16'h8000, 6'd5, 32'h0001_0000);
    queue_request(egsa_pkg::REQ_ACCUM, 16'd256, 6'd0, 32'h0001_0000);
    queue_request(egsa_pkg::REQ_ACCUM, 16'h7FFF, 6'd63, 32'h0001_0000);
    queue_request(egsa_pkg::REQ_CLEAR, 16'd0, 6'd0, 32'h0);
    queue_request(egsa_pkg::REQ_READ, 16'd0, 6'd0, 32'h0);
    queue_request(egsa_pkg::REQ_READ, 16'd255, 6'd63, 32'h0);
    queue_random(200, 2, 8, 8);
    drain();

    // Padding inside a small table.
    set_config(1'b1, 8'd3, 9'd16, 7'd8);
    queue_request(egsa_pkg::REQ_ACCUM, 16'd3, 6'd0, 32'h0000_0005);
    queue_request(egsa_pkg::REQ_READ, 16'd3, 6'd0, 32'h0);
    queue_request(egsa_pkg::REQ_ACCUM, 16'd15, 6'd7, 32'h0000_0001);
    queue_request(egsa_pkg::REQ_ACCUM, 16'd16, 6'd0, 32'h0000_0001);
    queue_request(egsa_pkg::REQ_ACCUM, 16'd0, 6'd8, 32'h0000_0001);
    queue_random(250, 3, 18, 10);
    drain();

    // Smallest table; the padding row lies outside it and still wins.
    set_config(1'b1, 8'd200, 9'd1, 7'd1);
    queue_request(egsa_pkg::REQ_ACCUM, 16'd200, 6'd0, 32'h0000_0007);
    queue_request(egsa_pkg::REQ_ACCUM, 16'd0, 6'd0, 32'h7FFF_FFFF);
    queue_request(egsa_pkg::REQ_READ, 16'd1, 6'd0, 32'h0);
    queue_random(100, 3, 3, 3);
    drain();

    // Full table, clear-heavy and back to back, enough clears for the tag to wrap.
    set_config(1'b1, 8'd255, 9'd256, 7'd64);
    hold_no_idle = 1'b1;
    queue_random(560, 50, 4, 4);
    drain();
    hold_no_idle = 1'b0;

    // Mid-size table with padding off.
    set_config(1'b0, 8'd128, 9'd200, 7'd33);
    queue_random(340, 2, 210, 40);
    drain();

    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
